// ===== sv/jet_pkg.sv =====
package jet_pkg;

  localparam int FRAC_BITS = 25;

  localparam logic [63:0] ESCAPE_NORM = 64'd16 << (2 * FRAC_BITS);

  localparam logic [1:0] REG_C_REAL          = 2'd0;
  localparam logic [1:0] REG_C_IMAG          = 2'd1;
  localparam logic [1:0] REG_ITERATION_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic out_full;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == '0 || v[65:31] == '1) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== sv/jet_datapath.sv =====
module jet_datapath (
  input  logic                clk,
  input  logic                rst,
  input  jet_pkg::cmd_t       cmd,
  output jet_pkg::status_t    status,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  start_real,
  input  logic signed [31:0]  start_imag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          iteration_count,
  output logic                bw_value
);
  import jet_pkg::*;

  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;
  logic [9:0]         iteration_limit;

  logic signed [31:0] z_re;
  logic signed [31:0] z_im;
  logic [9:0]         count;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic signed [63:0] ri;

  logic [63:0]        norm;
  logic signed [63:0] diff;
  logic signed [63:0] re_scaled;
  logic signed [64:0] re_sum;
  logic signed [64:0] cross_prod;
  logic signed [64:0] im_scaled;
  logic signed [65:0] im_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real          <= '0;
      c_imag          <= '0;
      iteration_limit <= 10'd100;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_C_REAL:          c_real          <= cfg_data;
        REG_C_IMAG:          c_imag          <= cfg_data;
        REG_ITERATION_LIMIT: iteration_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign norm       = 64'(rr) + 64'(ii);
  assign diff       = rr - ii;
  assign re_scaled  = diff >>> FRAC_BITS;
  assign re_sum     = 65'(re_scaled) + 65'(c_real);
  assign cross_prod = $signed({ri, 1'b0});
  assign im_scaled  = cross_prod >>> FRAC_BITS;
  assign im_sum     = 66'(im_scaled) + 66'(c_imag);

  assign status.stop     = (count >= iteration_limit) || (norm >= ESCAPE_NORM);
  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_re  <= start_real;
      z_im  <= start_imag;
      count <= '0;
    end else if (cmd.step) begin
      z_re  <= sat32(66'(re_sum));
      z_im  <= sat32(im_sum);
      count <= count + 10'd1;
    end
    if (cmd.mul) begin
      rr <= 64'(z_re) * 64'(z_re);
      ii <= 64'(z_im) * 64'(z_im);
      ri <= 64'(z_re) * 64'(z_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      iteration_count <= count;
      bw_value        <= count[0];
    end
  end

endmodule

// ===== sv/jet_ctrl.sv =====
module jet_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  jet_pkg::status_t status,
  output jet_pkg::cmd_t    cmd
);
  import jet_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (!status.stop) begin
          cmd.step   = 1'b1;
          state_next = ST_MUL;
        end else if (!status.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!status.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/julia_escape_time.sv =====
// channel  | handshake              | payload
// in       | in_valid / in_ready    | start_real, start_imag
// out      | out_valid / out_ready  | iteration_count, bw_value
// cfg      | cfg_write              | cfg_index, cfg_data
//
// Each iteration passes through a multiply state (three 32x32 products)
// and an update state (norm test, scale, add c, saturate).
// A point stops once its iteration count reaches the limit or its norm
// reaches the escape bound; with the reset limit of 100 at most 100 iterations.
// Reset is synchronous; c is cleared and the limit returns to 100.
// A result held in the output register stalls the next finish, not the input.
module julia_escape_time (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_real,
  input  logic signed [31:0] start_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         iteration_count,
  output logic               bw_value
);
  import jet_pkg::*;

  cmd_t    cmd;
  status_t status;

  jet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  jet_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start_real      (start_real),
    .start_imag      (start_imag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .iteration_count (iteration_count),
    .bw_value        (bw_value)
  );

endmodule
